// File: rtl/pccr_pkg.sv
// shared types and constants for the pairwise circle collision resolver
package pccr_pkg;

  localparam int unsigned MaxBallsDefault = 32;

  localparam logic CfgIdxMode  = 1'b0;
  localparam logic CfgIdxColor = 1'b1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } op_e;

  typedef enum logic {
    MODE_HIGHLIGHT = 1'b0,
    MODE_SWAP      = 1'b1
  } mode_e;

  // input beat
  typedef struct packed {
    logic               op;
    logic [15:0]        entity_id;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic [15:0]        radius;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [31:0]        color;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [15:0]        out_entity_id;
    logic signed [15:0] out_vel_x;
    logic signed [15:0] out_vel_y;
    logic [31:0]        out_color;
    logic               hit;
    logic               overflow;
    logic               last;
  } out_beat_t;

  // front to back command
  typedef struct packed {
    logic        run;
    logic [15:0] entity_id;
    logic [19:0] pos_x;
    logic [19:0] pos_y;
    logic [15:0] radius;
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [31:0] color;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_WR,
    ST_EMIT_RD,
    ST_EMIT
  } back_state_e;

endpackage

// File: rtl/pccr_if.sv
// valid/ready channel interfaces
interface pccr_in_if;
  pccr_pkg::in_beat_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pccr_out_if;
  pccr_pkg::out_beat_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/pccr_front.sv
// front end: accepts beats, filters overflow loads, feeds the command queue
module pccr_front #(
  parameter int unsigned MaxBalls = pccr_pkg::MaxBallsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pccr_in_if.sink            in_if,
  output pccr_pkg::cmd_t     cmd_o,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output logic               dropped_o,
  input  logic               run_done_i
);
  import pccr_pkg::*;

  localparam int unsigned CntW = $clog2(MaxBalls + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            drop_q, drop_d;
  logic            fire, full, is_run;

  assign in_if.ready = cmd_ready_i;
  assign fire   = in_if.valid & in_if.ready;
  assign is_run = (in_if.data.op == OP_RUN);
  assign full   = (count_q == CntW'(MaxBalls));

  assign cmd_valid_o = in_if.valid & (is_run | ~full);
  assign cmd_o = '{run: is_run, entity_id: in_if.data.entity_id,
                   pos_x: in_if.data.pos_x, pos_y: in_if.data.pos_y,
                   radius: in_if.data.radius, vel_x: in_if.data.vel_x,
                   vel_y: in_if.data.vel_y, color: in_if.data.color};
  assign dropped_o = drop_q;

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    if (run_done_i) drop_d = 1'b0;
    if (fire) begin
      if (is_run) count_d = '0;
      else if (full) drop_d = 1'b1;
      else count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end
endmodule

// File: rtl/pccr_queue.sv
// two-entry command queue between front and back
module pccr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pccr_pkg::cmd_t wr_data_i,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  output pccr_pkg::cmd_t rd_data_o,
  output logic           rd_valid_o,
  input  logic           rd_ready_i
);
  import pccr_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i & wr_ready_o;
  assign pop  = rd_valid_o & rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: rtl/pccr_back.sv
// back end: ball store, pair sweep and record emission
module pccr_back #(
  parameter int unsigned MaxBalls = pccr_pkg::MaxBallsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pccr_pkg::cmd_t  cmd_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  logic            mode_i,
  input  logic [31:0]     hl_color_i,
  input  logic            dropped_i,
  output logic            run_done_o,
  pccr_out_if.source      out_if
);
  import pccr_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxBalls);
  localparam int unsigned CntW = $clog2(MaxBalls + 1);

  // memory: static fields and dynamic fields
  logic [15:0] id_mem  [MaxBalls];
  logic [19:0] px_mem  [MaxBalls];
  logic [19:0] py_mem  [MaxBalls];
  logic [15:0] r_mem   [MaxBalls];
  logic [15:0] vx_mem  [MaxBalls];
  logic [15:0] vy_mem  [MaxBalls];
  logic [31:0] col_mem [MaxBalls];
  logic [MaxBalls-1:0] hit_q, hit_d;

  back_state_e st_q, st_d;
  logic [CntW-1:0] n_q, n_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d;
  logic            ovf_q, ovf_d;

  // registered reads of ball i and ball j
  logic [15:0] ia_id;
  logic [19:0] ia_px, ia_py, jb_px, jb_py;
  logic [15:0] ia_r, jb_r, ia_vx, ia_vy, jb_vx, jb_vy;
  logic [31:0] ia_col;
  logic [41:0] d2_q;
  logic [33:0] rs2_q;
  logic        hit_now;

  logic        wr_load, wr_swap, wr_hl;
  out_beat_t   ob_q;
  logic        ov_q;

  logic signed [20:0] dx, dy;
  logic [16:0]        rs;
  logic signed [41:0] dx_sq, dy_sq;
  logic [33:0]        rs_sq;

  assign dx = $signed({ia_px[19], ia_px}) - $signed({jb_px[19], jb_px});
  assign dy = $signed({ia_py[19], ia_py}) - $signed({jb_py[19], jb_py});
  assign rs = {1'b0, ia_r} + {1'b0, jb_r};
  // full-width squares, operands extended to the product width
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  assign rs_sq = {17'd0, rs} * {17'd0, rs};
  assign hit_now = ({1'b0, d2_q} <= {9'd0, rs2_q});

  always_ff @(posedge clk_i) begin
    ia_id  <= id_mem[i_d];
    ia_px  <= px_mem[i_d];  ia_py <= py_mem[i_d];  ia_r <= r_mem[i_d];
    ia_vx  <= vx_mem[i_d];  ia_vy <= vy_mem[i_d];  ia_col <= col_mem[i_d];
    jb_px  <= px_mem[j_d];  jb_py <= py_mem[j_d];  jb_r <= r_mem[j_d];
    jb_vx  <= vx_mem[j_d];  jb_vy <= vy_mem[j_d];
    d2_q   <= $unsigned(dx_sq) + $unsigned(dy_sq);
    rs2_q  <= rs_sq;
    if (wr_load) begin
      id_mem[n_q[IdxW-1:0]]  <= cmd_i.entity_id;
      px_mem[n_q[IdxW-1:0]]  <= cmd_i.pos_x;
      py_mem[n_q[IdxW-1:0]]  <= cmd_i.pos_y;
      r_mem[n_q[IdxW-1:0]]   <= cmd_i.radius;
      vx_mem[n_q[IdxW-1:0]]  <= cmd_i.vel_x;
      vy_mem[n_q[IdxW-1:0]]  <= cmd_i.vel_y;
      col_mem[n_q[IdxW-1:0]] <= cmd_i.color;
    end
    if (wr_swap) begin
      vx_mem[i_q] <= jb_vx; vy_mem[i_q] <= jb_vy;
      vx_mem[j_q] <= ia_vx; vy_mem[j_q] <= ia_vy;
    end
    if (wr_hl) begin
      col_mem[i_q] <= hl_color_i;
      col_mem[j_q] <= hl_color_i;
    end
  end

  always_comb begin
    st_d = st_q; n_d = n_q; i_d = i_q; j_d = j_q; hit_d = hit_q; ovf_d = ovf_q;
    cmd_ready_o = 1'b0; wr_load = 1'b0; wr_swap = 1'b0; wr_hl = 1'b0;
    run_done_o = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (!cmd_i.run) begin
            wr_load = 1'b1;
            hit_d[n_q[IdxW-1:0]] = 1'b0;
            n_d = n_q + 1'b1;
          end else begin
            ovf_d = dropped_i;
            run_done_o = 1'b1;
            i_d = '0;
            j_d = IdxW'(1);
            if (n_q == '0) st_d = ST_IDLE;
            else if (n_q == CntW'(1)) st_d = ST_EMIT_RD;
            else st_d = ST_RD;
          end
        end
      end
      ST_RD:  st_d = ST_CMP;
      ST_CMP: st_d = ST_WR;
      ST_WR: begin
        if (hit_now) begin
          hit_d[i_q] = 1'b1; hit_d[j_q] = 1'b1;
          if (mode_i == MODE_SWAP) wr_swap = 1'b1;
          else wr_hl = 1'b1;
        end
        if ({1'b0, j_q} + 1'b1 < n_q) begin
          j_d = j_q + 1'b1; st_d = ST_RD;
        end else if ({1'b0, i_q} + 2'd2 < n_q) begin
          i_d = i_q + 1'b1; j_d = i_q + 2'd2; st_d = ST_RD;
        end else begin
          i_d = '0; st_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: if (!ov_q || out_if.ready) st_d = ST_EMIT;
      ST_EMIT: begin
        if ({1'b0, i_q} + 1'b1 == n_q) begin
          n_d = '0; st_d = ST_IDLE;
        end else begin
          i_d = i_q + 1'b1; st_d = ST_EMIT_RD;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; n_q <= '0; i_q <= '0; j_q <= '0;
      hit_q <= '0; ovf_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; n_q <= n_d; i_q <= i_d; j_q <= j_d;
      hit_q <= hit_d; ovf_q <= ovf_d;
      if (st_q == ST_EMIT) ov_q <= 1'b1;
      else if (out_if.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_EMIT) begin
      ob_q <= '{out_entity_id: ia_id, out_vel_x: ia_vx, out_vel_y: ia_vy,
                out_color: ia_col, hit: hit_q[i_q], overflow: ovf_q,
                last: ({1'b0, i_q} + 1'b1 == n_q)};
    end
  end

  assign out_if.valid = ov_q;
  assign out_if.data  = ob_q;

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_EMIT |-> !ov_q) else $error("emit over a full output register");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(MaxBalls)) else $error("ball count out of range");
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_CMP |-> i_q < j_q) else $error("pair index order broken");
`endif
endmodule

// File: rtl/pairwise_circle_collision_resolver.sv
// top level of the pairwise circle collision resolver
// load beat: one per cycle while the queue has room
// run beat over n balls: each pair in the sweep goes through read, square, write
// back through the store; n(n-1)/2 pairs, then one emitted record per ball
// reset (rst_ni low, async): store empty, flags clear, control and config registers zero
module pairwise_circle_collision_resolver #(
  parameter int unsigned MaxBalls = pccr_pkg::MaxBallsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pccr_in_if.sink     in_if,
  pccr_out_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import pccr_pkg::*;

  // configuration registers
  logic        mode_q;
  logic [31:0] hl_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_HIGHLIGHT;
      hl_color_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgIdxMode) mode_q <= cfg_wdata_i[0];
      else hl_color_q <= cfg_wdata_i;
    end
  end

  // front -> queue -> back
  cmd_t fq_cmd, qb_cmd;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  logic dropped, run_done;

  pccr_front #(.MaxBalls(MaxBalls)) u_front (
    .clk_i, .rst_ni, .in_if,
    .cmd_o(fq_cmd), .cmd_valid_o(fq_valid), .cmd_ready_i(fq_ready),
    .dropped_o(dropped), .run_done_i(run_done)
  );

  pccr_queue u_queue (
    .clk_i, .rst_ni,
    .wr_data_i(fq_cmd), .wr_valid_i(fq_valid), .wr_ready_o(fq_ready),
    .rd_data_o(qb_cmd), .rd_valid_o(qb_valid), .rd_ready_i(qb_ready)
  );

  // overflow flag is a side signal, not part of the command: sample at run pop
  pccr_back #(.MaxBalls(MaxBalls)) u_back (
    .clk_i, .rst_ni,
    .cmd_i(qb_cmd), .cmd_valid_i(qb_valid), .cmd_ready_o(qb_ready),
    .mode_i(mode_q), .hl_color_i(hl_color_q),
    .dropped_i(dropped), .run_done_o(run_done), .out_if
  );
endmodule
